// ----- hw/rtl/kedp_pkg.sv -----
package kedp_pkg;

  localparam int unsigned MaxKeyLen = 8;

  localparam int unsigned CharW  = 8;
  localparam int unsigned KeyW   = 64;
  localparam int unsigned LenW   = 4;
  localparam int unsigned PosW   = 4;
  localparam int unsigned ValueW = 32;
  localparam int unsigned StatW  = 2;

  localparam logic [CharW-1:0] ChEquals  = 8'h3d;
  localparam logic [CharW-1:0] ChZero    = 8'h30;
  localparam logic [CharW-1:0] ChNine    = 8'h39;
  localparam logic [CharW-1:0] ChSpace   = 8'h20;
  localparam logic [CharW-1:0] ChNul     = 8'h00;
  localparam logic [CharW-1:0] ChNewline = 8'h0a;

  typedef enum logic [StatW-1:0] {
    ST_OK    = 2'd0,
    ST_NAME  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_BAD   = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    REG_KEY_CHARS  = 1'b0,
    REG_KEY_LENGTH = 1'b1
  } reg_index_t;

  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_KEY    = 6'b000010,
    PH_EQ     = 6'b000100,
    PH_FIRST  = 6'b001000,
    PH_DIGITS = 6'b010000,
    PH_DONE   = 6'b100000
  } phase_t;

  typedef struct packed {
    logic              valid;
    status_t           status;
    logic [ValueW-1:0] value;
  } result_t;

endpackage

// ----- hw/rtl/key_equals_decimal_parser_top.sv -----
// Key=value decimal parser. Each request on s_axis is one byte of a text line
// (tuser high on the first byte). The line must start with the key set by the
// key_chars and key_length registers, then '=', then decimal digits ended by
// a space, NUL or newline. One response per line is sent on m_axis once the
// outcome is known: status 0 ok with the 32-bit value, 1 name mismatch,
// 2 empty value, 3 bad digit or overflow (value reads 0 unless ok). Bytes
// after the response are dropped until the next first byte; a line without a
// terminator gives no response. One byte per cycle unless m_axis stalls; data
// passes an input register, then a result register. The user must write the
// registers on the cfg channel while no line is in flight; block doesn't check.
module key_equals_decimal_parser_top #(
  parameter int unsigned MAX_KEY_LEN = kedp_pkg::MaxKeyLen
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
  input  logic        s_axis_tuser,   // [0] line_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [1:0] status, [33:2] parsed_value, rest 0
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic                             in_valid;
  logic [kedp_pkg::CharW-1:0]       in_char;
  logic                             in_start;
  logic                             step;
  logic [kedp_pkg::KeyW-1:0]        key_chars;
  logic [kedp_pkg::LenW-1:0]        key_len;
  kedp_pkg::result_t                result;
  kedp_pkg::status_t                out_status;
  logic [kedp_pkg::ValueW-1:0]      out_value;

  assign cfg_ready     = 1'b1;
  assign step          = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char  <= s_axis_tdata;
      in_start <= s_axis_tuser;
    end
  end

  kedp_cfg #(
    .MAX_KEY_LEN (MAX_KEY_LEN)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (kedp_pkg::reg_index_t'(cfg_index)),
    .cfg_data  (cfg_data),
    .key_chars (key_chars),
    .key_len   (key_len)
  );

  kedp_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .char_in    (in_char),
    .line_start (in_start),
    .key_chars  (key_chars),
    .key_len    (key_len),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (step) begin
      m_axis_tvalid <= result.valid;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && result.valid) begin
      out_status <= result.status;
      out_value  <= result.value;
    end
  end

  assign m_axis_tdata = {6'b000000, out_value, out_status};

`ifndef SYNTH
  a_value_zero_unless_ok: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && out_status != kedp_pkg::ST_OK |-> out_value == '0)
    else $error("nonzero value with failing status");

  a_reset_clears_output: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("response valid after reset");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> in_valid && m_axis_tvalid && !m_axis_tready)
    else $error("input stalled while pipeline can advance");
`endif

endmodule

// ----- hw/rtl/kedp_cfg.sv -----
module kedp_cfg #(
  parameter int unsigned MAX_KEY_LEN = kedp_pkg::MaxKeyLen
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  input  kedp_pkg::reg_index_t         cfg_index,
  input  logic [kedp_pkg::KeyW-1:0]    cfg_data,
  output logic [kedp_pkg::KeyW-1:0]    key_chars,
  output logic [kedp_pkg::LenW-1:0]    key_len
);

  localparam logic [kedp_pkg::LenW-1:0] LenMax = kedp_pkg::LenW'(MAX_KEY_LEN);

  logic [kedp_pkg::LenW-1:0] key_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_chars  <= '0;
      key_length <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        kedp_pkg::REG_KEY_CHARS:  key_chars  <= cfg_data;
        kedp_pkg::REG_KEY_LENGTH: key_length <= cfg_data[kedp_pkg::LenW-1:0];
        default: ;
      endcase
    end
  end

  assign key_len = (key_length > LenMax) ? LenMax : key_length;

endmodule

// ----- hw/rtl/kedp_parse.sv -----
module kedp_parse (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic [kedp_pkg::CharW-1:0]    char_in,
  input  logic                          line_start,
  input  logic [kedp_pkg::KeyW-1:0]     key_chars,
  input  logic [kedp_pkg::LenW-1:0]     key_len,
  output kedp_pkg::result_t             result
);

  localparam int unsigned ProdW = kedp_pkg::ValueW + 4;

  kedp_pkg::phase_t                phase, phase_next, ph;
  logic [kedp_pkg::PosW-1:0]       position, position_next, pos, pos_inc;
  logic [kedp_pkg::ValueW-1:0]     accumulator, accumulator_next, acc;
  logic                            overflowed, overflowed_next, ovf;
  logic [kedp_pkg::CharW-1:0]      want;
  logic [ProdW-1:0]                prod;
  logic                            is_term, is_digit;

  always_comb begin
    ph  = line_start ? kedp_pkg::PH_KEY : phase;
    pos = line_start ? '0 : position;
    acc = line_start ? '0 : accumulator;
    ovf = line_start ? 1'b0 : overflowed;

    pos_inc = pos + kedp_pkg::PosW'(1);
    want    = key_chars[{pos[2:0], 3'b000} +: kedp_pkg::CharW];
    is_term = (char_in == kedp_pkg::ChSpace) || (char_in == kedp_pkg::ChNul)
           || (char_in == kedp_pkg::ChNewline);
    is_digit = (char_in >= kedp_pkg::ChZero) && (char_in <= kedp_pkg::ChNine);
    // acc * 10 + digit
    prod = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0}
         + ProdW'(char_in - kedp_pkg::ChZero);

    phase_next       = ph;
    position_next    = pos;
    accumulator_next = acc;
    overflowed_next  = ovf;
    result.valid     = 1'b0;
    result.status    = kedp_pkg::ST_OK;
    result.value     = '0;

    unique case (ph)
      kedp_pkg::PH_KEY: begin
        if (pos < key_len) begin
          if (char_in == kedp_pkg::ChNul || char_in != want) begin
            result.valid  = 1'b1;
            result.status = kedp_pkg::ST_NAME;
          end else begin
            position_next = pos_inc;
            if (pos_inc >= key_len) phase_next = kedp_pkg::PH_EQ;
          end
        end else if (char_in == kedp_pkg::ChEquals) begin
          phase_next = kedp_pkg::PH_FIRST;
        end else begin
          result.valid  = 1'b1;
          result.status = kedp_pkg::ST_NAME;
        end
      end
      kedp_pkg::PH_EQ: begin
        if (char_in == kedp_pkg::ChEquals) begin
          phase_next = kedp_pkg::PH_FIRST;
        end else begin
          result.valid  = 1'b1;
          result.status = kedp_pkg::ST_NAME;
        end
      end
      kedp_pkg::PH_FIRST: begin
        if (is_term) begin
          result.valid  = 1'b1;
          result.status = kedp_pkg::ST_EMPTY;
        end else if (!is_digit) begin
          result.valid  = 1'b1;
          result.status = kedp_pkg::ST_BAD;
        end else begin
          accumulator_next = prod[kedp_pkg::ValueW-1:0];
          overflowed_next  = ovf | (|prod[ProdW-1:kedp_pkg::ValueW]);
          phase_next       = kedp_pkg::PH_DIGITS;
        end
      end
      kedp_pkg::PH_DIGITS: begin
        if (is_term) begin
          result.valid  = 1'b1;
          result.status = ovf ? kedp_pkg::ST_BAD : kedp_pkg::ST_OK;
          result.value  = ovf ? '0 : acc;
        end else if (!is_digit) begin
          result.valid  = 1'b1;
          result.status = kedp_pkg::ST_BAD;
        end else begin
          accumulator_next = prod[kedp_pkg::ValueW-1:0];
          overflowed_next  = ovf | (|prod[ProdW-1:kedp_pkg::ValueW]);
        end
      end
      default: ;
    endcase

    if (result.valid) phase_next = kedp_pkg::PH_DONE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= kedp_pkg::PH_IDLE;
      position    <= '0;
      accumulator <= '0;
      overflowed  <= 1'b0;
    end else if (step) begin
      phase       <= phase_next;
      position    <= position_next;
      accumulator <= accumulator_next;
      overflowed  <= overflowed_next;
    end
  end

endmodule
